[hdl/bpt_pkg.sv]
// ----------------------------------------------------------------------------
// bpt_pkg
// Shared types and constants for the barometer pressure and temperature
// compensation pipeline.
// ----------------------------------------------------------------------------
package bpt_pkg;

    localparam int NumCal    = 6;
    localparam int CfgIdxW   = 3;
    localparam int CalW      = 16;
    localparam int RawW      = 24;
    localparam int PressW    = 20;
    localparam int TempW     = 15;
    localparam int NumStages = 8;

    // calibration register indexes
    localparam logic [CfgIdxW-1:0] CAL_C1 = 3'd0;
    localparam logic [CfgIdxW-1:0] CAL_C2 = 3'd1;
    localparam logic [CfgIdxW-1:0] CAL_C3 = 3'd2;
    localparam logic [CfgIdxW-1:0] CAL_C4 = 3'd3;
    localparam logic [CfgIdxW-1:0] CAL_C5 = 3'd4;
    localparam logic [CfgIdxW-1:0] CAL_C6 = 3'd5;

    // temperatures in 0.01 C
    localparam int TempRef = 2000;
    localparam int TempLow = -1500;

    // output limits
    localparam logic [PressW-1:0]       PressMax    = 20'd1048575;
    localparam logic signed [TempW-1:0] TempDeciMin = -15'sd4000;
    localparam logic signed [TempW-1:0] TempDeciMax = 15'sd8500;

    // n / 10 == (n * Div10Mul) >> Div10Shift for n < 2^22
    localparam logic [19:0] Div10Mul   = 20'd838861;
    localparam int          Div10Shift = 23;

    typedef struct packed {
        logic [CalW-1:0] c1;
        logic [CalW-1:0] c2;
        logic [CalW-1:0] c3;
        logic [CalW-1:0] c4;
        logic [CalW-1:0] c5;
        logic [CalW-1:0] c6;
    } t_cal;

    typedef struct packed {
        logic [NumStages-1:0] en;
        logic [NumStages-1:0] vld;
    } t_pipe_ctrl;

endpackage

[hdl/bpt_cal_regs.sv]
// ----------------------------------------------------------------------------
// bpt_cal_regs
// Calibration word register file, written through a plain write port.
// ----------------------------------------------------------------------------
module bpt_cal_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [bpt_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  logic [bpt_pkg::CalW-1:0]      i_cfg_data,
    output bpt_pkg::t_cal                 o_cal
);

    bpt_pkg::t_cal r_cal;
    bpt_pkg::t_cal n_cal;

    always_comb begin
        n_cal = r_cal;
        if (i_cfg_we) begin
            case (i_cfg_index)
                bpt_pkg::CAL_C1: n_cal.c1 = i_cfg_data;
                bpt_pkg::CAL_C2: n_cal.c2 = i_cfg_data;
                bpt_pkg::CAL_C3: n_cal.c3 = i_cfg_data;
                bpt_pkg::CAL_C4: n_cal.c4 = i_cfg_data;
                bpt_pkg::CAL_C5: n_cal.c5 = i_cfg_data;
                bpt_pkg::CAL_C6: n_cal.c6 = i_cfg_data;
                default: n_cal = r_cal;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal <= '0;
        end else begin
            r_cal <= n_cal;
        end
    end

    assign o_cal = r_cal;

endmodule

[hdl/bpt_pipe_ctrl.sv]
// ----------------------------------------------------------------------------
// bpt_pipe_ctrl
// Stage valid bits and per-stage load enables; a stage loads when it is
// empty or the stage after it moves, so bubbles collapse under stall.
// ----------------------------------------------------------------------------
module bpt_pipe_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_out_stall,
    output bpt_pkg::t_pipe_ctrl   o_ctrl
);

    localparam int NS = bpt_pkg::NumStages;

    logic [NS-1:0] r_vld;
    logic [NS-1:0] n_vld;
    logic [NS-1:0] en;
    logic          in_acc;
    logic          out_acc;

    always_comb begin
        en[NS-1] = !r_vld[NS-1] || !i_out_stall;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
        n_vld[0] = en[0] ? i_in_valid : r_vld[0];
        for (int k = 1; k < NS; k++) begin
            n_vld[k] = en[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign in_acc     = i_in_valid && en[0];
    assign out_acc    = r_vld[NS-1] && !i_out_stall;
    assign o_ctrl.en  = en;
    assign o_ctrl.vld = r_vld;

    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_vld == '0))
        else $error("pipeline not empty after reset");

    a_occupancy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n |=> ($countones(r_vld) == $past($countones(r_vld))
                     + ($past(in_acc) ? 1 : 0) - ($past(out_acc) ? 1 : 0)))
        else $error("item lost or duplicated in pipeline");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en[0] |-> ((r_vld == '1) && i_out_stall))
        else $error("input stalled while pipeline has room");

endmodule

[hdl/bpt_comp_core.sv]
// ----------------------------------------------------------------------------
// bpt_comp_core
// Eight-stage compensation datapath: first-order terms, second-order
// correction, split pressure product, divide by ten and saturation.
// ----------------------------------------------------------------------------
module bpt_comp_core (
    input  logic                              i_clk,
    input  bpt_pkg::t_pipe_ctrl               i_ctrl,
    input  bpt_pkg::t_cal                     i_cal,
    input  logic [bpt_pkg::RawW-1:0]          i_raw_pressure,
    input  logic [bpt_pkg::RawW-1:0]          i_raw_temperature,
    output logic [bpt_pkg::PressW-1:0]        o_pressure_pa,
    output logic signed [bpt_pkg::TempW-1:0]  o_temperature_deci
);

    localparam int RW = bpt_pkg::RawW;

    // stage 1: dT
    logic [RW-1:0]        r_s1_d1;
    logic signed [24:0]   r_s1_dt;
    logic signed [24:0]   n_s1_dt;

    // stage 2: first-order products
    logic [RW-1:0]        r_s2_d1;
    logic signed [41:0]   r_s2_p6, r_s2_p4, r_s2_p3;
    logic signed [41:0]   n_s2_p6, n_s2_p4, n_s2_p3;
    logic signed [49:0]   r_s2_pdd;
    logic signed [49:0]   n_s2_pdd;

    // stage 3: TEMP-2000, OFF, SENS, T2
    logic [RW-1:0]        r_s3_d1;
    logic signed [18:0]   r_s3_a, n_s3_a;
    logic signed [35:0]   r_s3_off, n_s3_off;
    logic signed [35:0]   r_s3_sens, n_s3_sens;
    logic [17:0]          r_s3_t2;

    // stage 4: squares, corrected temperature
    logic [RW-1:0]        r_s4_d1;
    logic signed [19:0]   n_b;
    logic signed [37:0]   n_a_sq, n_b_sq;
    logic [34:0]          r_s4_sq, r_s4_sq2;
    logic                 r_s4_lt, r_s4_lt2;
    logic signed [35:0]   r_s4_off, r_s4_sens;
    logic signed [19:0]   r_s4_temp, n_s4_temp;

    // stage 5: second-order applied
    logic [RW-1:0]        r_s5_d1;
    logic [37:0]          sq5, sq7, sq11;
    logic [37:0]          n_off2, n_sens2;
    logic signed [39:0]   r_s5_off, n_s5_off;
    logic signed [39:0]   r_s5_sens, n_s5_sens;
    logic                 r_s5_tneg;
    logic [19:0]          r_s5_tmag, n_s5_tmag;

    // stage 6: partial products
    logic signed [39:0]   r_s6_off;
    logic [43:0]          r_s6_plo, n_s6_plo;
    logic signed [44:0]   r_s6_phi, n_s6_phi;
    logic [39:0]          r_s6_tq, n_s6_tq;
    logic                 r_s6_tneg;

    // stage 7: D1*SENS >> 21, temperature quotient
    logic signed [39:0]   r_s7_off;
    logic signed [65:0]   n_prod;
    logic signed [44:0]   r_s7_s;
    logic [16:0]          n_q;
    logic signed [17:0]   n_t;
    logic signed [bpt_pkg::TempW-1:0] r_s7_t, n_s7_t;

    // stage 8: pressure and output register
    logic signed [45:0]   n_x;
    logic [bpt_pkg::PressW-1:0]       r_s8_p, n_s8_p;
    logic signed [bpt_pkg::TempW-1:0] r_s8_t;

    // ---- stage 1
    assign n_s1_dt = $signed({1'b0, i_raw_temperature}) - $signed({1'b0, i_cal.c5, 8'h00});

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en[0]) begin
            r_s1_d1 <= i_raw_pressure;
            r_s1_dt <= n_s1_dt;
        end
    end

    // ---- stage 2
    assign n_s2_p6  = r_s1_dt * $signed({1'b0, i_cal.c6});
    assign n_s2_p4  = r_s1_dt * $signed({1'b0, i_cal.c4});
    assign n_s2_p3  = r_s1_dt * $signed({1'b0, i_cal.c3});
    assign n_s2_pdd = r_s1_dt * r_s1_dt;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en[1]) begin
            r_s2_d1  <= r_s1_d1;
            r_s2_p6  <= n_s2_p6;
            r_s2_p4  <= n_s2_p4;
            r_s2_p3  <= n_s2_p3;
            r_s2_pdd <= n_s2_pdd;
        end
    end

    // ---- stage 3
    assign n_s3_a    = 19'(r_s2_p6 >>> 23);
    assign n_s3_off  = $signed({4'b0, i_cal.c2, 16'h0000}) + 36'(r_s2_p4 >>> 7);
    assign n_s3_sens = $signed({5'b0, i_cal.c1, 15'h0000}) + 36'(r_s2_p3 >>> 8);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en[2]) begin
            r_s3_d1   <= r_s2_d1;
            r_s3_a    <= n_s3_a;
            r_s3_off  <= n_s3_off;
            r_s3_sens <= n_s3_sens;
            r_s3_t2   <= r_s2_pdd[48:31];
        end
    end

    // ---- stage 4
    assign n_b       = 20'(r_s3_a) + 20'(bpt_pkg::TempRef - bpt_pkg::TempLow);
    assign n_a_sq    = r_s3_a * r_s3_a;
    assign n_b_sq    = n_b * n_b;
    assign n_s4_temp = 20'(r_s3_a) + 20'(bpt_pkg::TempRef)
                     - (r_s3_a[18] ? $signed({2'b00, r_s3_t2}) : 20'sd0);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en[3]) begin
            r_s4_d1   <= r_s3_d1;
            r_s4_sq   <= n_a_sq[34:0];
            r_s4_sq2  <= n_b_sq[34:0];
            r_s4_lt   <= r_s3_a[18];
            r_s4_lt2  <= n_b[19];
            r_s4_off  <= r_s3_off;
            r_s4_sens <= r_s3_sens;
            r_s4_temp <= n_s4_temp;
        end
    end

    // ---- stage 5
    assign sq5  = ({3'b000, r_s4_sq} << 2) + {3'b000, r_s4_sq};
    assign sq7  = ({3'b000, r_s4_sq2} << 3) - {3'b000, r_s4_sq2};
    assign sq11 = ({3'b000, r_s4_sq2} << 3) + ({3'b000, r_s4_sq2} << 1) + {3'b000, r_s4_sq2};

    always_comb begin
        n_off2  = '0;
        n_sens2 = '0;
        if (r_s4_lt) begin
            n_off2  = (sq5 >> 1) + (r_s4_lt2 ? sq7 : 38'd0);
            n_sens2 = (sq5 >> 2) + (r_s4_lt2 ? (sq11 >> 1) : 38'd0);
        end
    end

    assign n_s5_off  = 40'(r_s4_off) - $signed({2'b00, n_off2});
    assign n_s5_sens = 40'(r_s4_sens) - $signed({2'b00, n_sens2});
    assign n_s5_tmag = r_s4_temp[19] ? 20'(-r_s4_temp) : 20'(r_s4_temp);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en[4]) begin
            r_s5_d1   <= r_s4_d1;
            r_s5_off  <= n_s5_off;
            r_s5_sens <= n_s5_sens;
            r_s5_tneg <= r_s4_temp[19];
            r_s5_tmag <= n_s5_tmag;
        end
    end

    // ---- stage 6: D1*SENS split at bit 20 of SENS
    assign n_s6_plo = r_s5_d1 * r_s5_sens[19:0];
    assign n_s6_phi = $signed({1'b0, r_s5_d1}) * $signed(r_s5_sens[39:20]);
    assign n_s6_tq  = r_s5_tmag * bpt_pkg::Div10Mul;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en[5]) begin
            r_s6_off  <= r_s5_off;
            r_s6_plo  <= n_s6_plo;
            r_s6_phi  <= n_s6_phi;
            r_s6_tq   <= n_s6_tq;
            r_s6_tneg <= r_s5_tneg;
        end
    end

    // ---- stage 7
    assign n_prod = (66'(r_s6_phi) <<< 20) + $signed({22'b0, r_s6_plo});
    assign n_q    = r_s6_tq[39:bpt_pkg::Div10Shift];
    assign n_t    = r_s6_tneg ? -$signed({1'b0, n_q}) : $signed({1'b0, n_q});

    always_comb begin
        if (n_t < bpt_pkg::TempDeciMin) begin
            n_s7_t = bpt_pkg::TempDeciMin;
        end else if (n_t > bpt_pkg::TempDeciMax) begin
            n_s7_t = bpt_pkg::TempDeciMax;
        end else begin
            n_s7_t = n_t[bpt_pkg::TempW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en[6]) begin
            r_s7_off <= r_s6_off;
            r_s7_s   <= $signed(n_prod[65:21]);
            r_s7_t   <= n_s7_t;
        end
    end

    // ---- stage 8: (x >> 15) saturated to 0..PressMax
    assign n_x = 46'(r_s7_s) - 46'(r_s7_off);

    always_comb begin
        if (n_x[45]) begin
            n_s8_p = '0;
        end else if (|n_x[44:35]) begin
            n_s8_p = bpt_pkg::PressMax;
        end else begin
            n_s8_p = n_x[34:15];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en[7]) begin
            r_s8_p <= n_s8_p;
            r_s8_t <= r_s7_t;
        end
    end

    assign o_pressure_pa      = r_s8_p;
    assign o_temperature_deci = r_s8_t;

endmodule

[hdl/baro_pressure_temp_compensation.sv]
// An input transfer is registered in stage 1 and leaves from the stage-8 output register.
// Throughput: one item per cycle while the output is not stalled; eight register stages, set by the split
//   24 x 40-bit pressure product and the second-order correction.
// Output stall holds the pipeline; empty stages keep filling while stalled.
// Reset (synchronous, active low) empties the pipeline and clears C1..C6.
// ----------------------------------------------------------------------------
// baro_pressure_temp_compensation
// Barometer compensation: raw pressure and temperature conversions in,
// pressure in Pa and temperature in 0.1 C out.
// ----------------------------------------------------------------------------
module baro_pressure_temp_compensation (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [bpt_pkg::CfgIdxW-1:0]       i_cfg_index,
    input  logic [bpt_pkg::CalW-1:0]          i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [bpt_pkg::RawW-1:0]          i_raw_pressure,
    input  logic [bpt_pkg::RawW-1:0]          i_raw_temperature,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [bpt_pkg::PressW-1:0]        o_pressure_pa,
    output logic signed [bpt_pkg::TempW-1:0]  o_temperature_deci
);

    bpt_pkg::t_cal       cal;
    bpt_pkg::t_pipe_ctrl ctrl;

    bpt_cal_regs u_cal_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cal       (cal)
    );

    bpt_pipe_ctrl u_pipe_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .o_ctrl      (ctrl)
    );

    bpt_comp_core u_comp_core (
        .i_clk              (i_clk),
        .i_ctrl             (ctrl),
        .i_cal              (cal),
        .i_raw_pressure     (i_raw_pressure),
        .i_raw_temperature  (i_raw_temperature),
        .o_pressure_pa      (o_pressure_pa),
        .o_temperature_deci (o_temperature_deci)
    );

    assign o_in_stall  = !ctrl.en[0];
    assign o_out_valid = ctrl.vld[bpt_pkg::NumStages-1];

endmodule

[bench/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the barometer compensation pipeline. A table of
// directed readings under fixed calibration sets is followed by random
// phases with fresh calibration and varying back-pressure. Every result is
// checked in order, against a fixed expected reading or an in-bench compensation model.
// ----------------------------------------------------------------------------
module testbench;

    localparam int QuietLimit  = 4000;
    localparam int NumPhases   = 8;
    localparam int PhaseItems  = 85;
    localparam int DirRows     = 21;
    localparam int HoldCycles  = 64;

    localparam logic [bpt_pkg::CfgIdxW-1:0] IdxPastEnd =
        bpt_pkg::CfgIdxW'(bpt_pkg::NumCal);
    localparam logic [bpt_pkg::CfgIdxW-1:0] IdxTop     = '1;

    localparam bpt_pkg::t_cal TypicalCal = {16'd40127, 16'd36924, 16'd23317,
                                            16'd23282, 16'd33464, 16'd28312};

    typedef enum logic [2:0] {
        SET_ZERO,
        SET_TYPICAL,
        SET_PSAT,
        SET_HOT,
        SET_FULL
    } t_cal_set;

    typedef struct packed {
        logic [bpt_pkg::PressW-1:0]       p;
        logic signed [bpt_pkg::TempW-1:0] t;
    } t_reading;

    typedef struct packed {
        t_cal_set                         cal;
        logic [bpt_pkg::RawW-1:0]         d1;
        logic [bpt_pkg::RawW-1:0]         d2;
        logic                             fixed;
        logic [bpt_pkg::PressW-1:0]       p;
        logic signed [bpt_pkg::TempW-1:0] t;
    } t_row;

    // fixed rows carry the expected reading; the rest go through the model
    localparam t_row DirectedRows [DirRows] = '{
        '{SET_ZERO,    24'h000000,  24'h000000,  1'b1, 20'd0,       15'sd200},
        '{SET_ZERO,    24'hFFFFFF,  24'hFFFFFF,  1'b1, 20'd0,       15'sd200},
        '{SET_ZERO,    24'hAAAAAA,  24'h555555,  1'b1, 20'd0,       15'sd200},
        '{SET_TYPICAL, 24'd9085466, 24'd8569150, 1'b0, 20'd0,       15'sd0},
        '{SET_TYPICAL, 24'd9085466, 24'd8000000, 1'b0, 20'd0,       15'sd0},
        '{SET_TYPICAL, 24'd9085466, 24'd7000000, 1'b0, 20'd0,       15'sd0},
        '{SET_TYPICAL, 24'd9085466, 24'h000000,  1'b0, 20'd0,       15'sd0},
        '{SET_TYPICAL, 24'd9085466, 24'hFFFFFF,  1'b0, 20'd0,       15'sd0},
        '{SET_TYPICAL, 24'h000000,  24'd8569150, 1'b0, 20'd0,       15'sd0},
        '{SET_TYPICAL, 24'hFFFFFF,  24'd8569150, 1'b0, 20'd0,       15'sd0},
        '{SET_TYPICAL, 24'h555555,  24'hAAAAAA,  1'b0, 20'd0,       15'sd0},
        '{SET_TYPICAL, 24'hAAAAAA,  24'h555555,  1'b0, 20'd0,       15'sd0},
        '{SET_PSAT,    24'hFFFFFF,  24'hFFFFFF,  1'b1, 20'd1048575, 15'sd200},
        '{SET_PSAT,    24'h000000,  24'hFFFFFF,  1'b1, 20'd0,       15'sd200},
        '{SET_PSAT,    24'h800000,  24'h800000,  1'b0, 20'd0,       15'sd0},
        '{SET_HOT,     24'h000000,  24'hFFFFFF,  1'b1, 20'd0,       15'sd8500},
        '{SET_HOT,     24'h123456,  24'h000000,  1'b1, 20'd0,       15'sd200},
        '{SET_FULL,    24'hFFFFFF,  24'h000000,  1'b0, 20'd0,       15'sd0},
        '{SET_FULL,    24'h000000,  24'hFFFFFF,  1'b0, 20'd0,       15'sd0},
        '{SET_FULL,    24'hFFFFFF,  24'hFFFFFF,  1'b0, 20'd0,       15'sd0},
        '{SET_ZERO,    24'hFFFFFF,  24'h000000,  1'b1, 20'd0,       15'sd200}
    };

    logic                             i_clk;
    logic                             i_rst_n            = 1'b0;
    logic                             i_cfg_we           = 1'b0;
    logic [bpt_pkg::CfgIdxW-1:0]      i_cfg_index        = '0;
    logic [bpt_pkg::CalW-1:0]         i_cfg_data         = '0;
    logic                             i_in_valid         = 1'b0;
    logic                             o_in_stall;
    logic [bpt_pkg::RawW-1:0]         i_raw_pressure     = '0;
    logic [bpt_pkg::RawW-1:0]         i_raw_temperature  = '0;
    logic                             o_out_valid;
    logic                             i_out_stall        = 1'b0;
    logic [bpt_pkg::PressW-1:0]       o_pressure_pa;
    logic signed [bpt_pkg::TempW-1:0] o_temperature_deci;

    bpt_pkg::t_cal cal_model = '0;
    t_reading      expected_readings [$];
    int            n_errors       = 0;
    int            send_idle_pct  = 0;
    int            recv_stall_pct = 0;
    int            stall_hold_len = 0;
    int            quiet_cycles   = 0;

    baro_pressure_temp_compensation i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_raw_pressure     (i_raw_pressure),
        .i_raw_temperature  (i_raw_temperature),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_pressure_pa      (o_pressure_pa),
        .o_temperature_deci (o_temperature_deci)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // first- and second-order compensation with saturation
    function automatic t_reading compensate(input logic [bpt_pkg::RawW-1:0] raw_p,
                                            input logic [bpt_pkg::RawW-1:0] raw_t);
        longint   d1, dt, temp, off, sens, t2, off2, sens2, sq, p, t;
        t_reading r;
        d1    = longint'(raw_p);
        dt    = longint'(raw_t) - longint'(cal_model.c5) * 256;
        temp  = bpt_pkg::TempRef + ((dt * longint'(cal_model.c6)) >>> 23);
        off   = longint'(cal_model.c2) * 65536 + ((longint'(cal_model.c4) * dt) >>> 7);
        sens  = longint'(cal_model.c1) * 32768 + ((longint'(cal_model.c3) * dt) >>> 8);
        t2    = 0;
        off2  = 0;
        sens2 = 0;
        if (temp < bpt_pkg::TempRef) begin
            sq    = (temp - bpt_pkg::TempRef) * (temp - bpt_pkg::TempRef);
            t2    = (dt * dt) >>> 31;
            off2  = (5 * sq) >>> 1;
            sens2 = (5 * sq) >>> 2;
            if (temp < bpt_pkg::TempLow) begin
                sq    = (temp - bpt_pkg::TempLow) * (temp - bpt_pkg::TempLow);
                off2  = off2 + 7 * sq;
                sens2 = sens2 + ((11 * sq) >>> 1);
            end
        end
        temp = temp - t2;
        off  = off - off2;
        sens = sens - sens2;
        p = (((d1 * sens) >>> 21) - off) >>> 15;
        if (p < 0) p = 0;
        if (p > longint'(bpt_pkg::PressMax)) p = longint'(bpt_pkg::PressMax);
        t = temp / 10;
        if (t < longint'(bpt_pkg::TempDeciMin)) t = longint'(bpt_pkg::TempDeciMin);
        if (t > longint'(bpt_pkg::TempDeciMax)) t = longint'(bpt_pkg::TempDeciMax);
        r.p = p[bpt_pkg::PressW-1:0];
        r.t = t[bpt_pkg::TempW-1:0];
        return r;
    endfunction

    function automatic bpt_pkg::t_cal cal_of(input t_cal_set s);
        case (s)
            SET_TYPICAL: return TypicalCal;
            SET_PSAT:    return {16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000};
            SET_HOT:     return {16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF};
            SET_FULL:    return '1;
            default:     return '0;
        endcase
    endfunction

    function automatic logic [bpt_pkg::CalW-1:0] vary_word(
        input logic [bpt_pkg::CalW-1:0] nominal);
        case ($urandom_range(3))
            0:       return bpt_pkg::CalW'($urandom);
            1:       return ($urandom_range(1) == 1) ? '1 : '0;
            default: return nominal + bpt_pkg::CalW'($urandom_range(8191)) - 16'd4096;
        endcase
    endfunction

    // raw temperature, either uniform or spread around the calibrated reference point
    function automatic logic [bpt_pkg::RawW-1:0] pick_temperature(input bpt_pkg::t_cal c);
        longint v;
        if ($urandom_range(2) == 0) return bpt_pkg::RawW'($urandom);
        v = longint'($urandom) & ((longint'(1) << $urandom_range(24)) - 1);
        if ($urandom_range(1) == 1) v = -v;
        v = v + longint'(c.c5) * 256;
        if (v < 0) v = 0;
        if (v > 64'hFFFFFF) v = 64'hFFFFFF;
        return v[bpt_pkg::RawW-1:0];
    endfunction

    // leaves the write enable high; the caller lowers it after the last write
    task automatic cfg_write(input logic [bpt_pkg::CfgIdxW-1:0] idx,
                             input logic [bpt_pkg::CalW-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
    endtask

    task automatic program_cal(input bpt_pkg::t_cal c);
        cfg_write(bpt_pkg::CAL_C1, c.c1);
        cfg_write(bpt_pkg::CAL_C2, c.c2);
        cfg_write(bpt_pkg::CAL_C3, c.c3);
        cfg_write(bpt_pkg::CAL_C4, c.c4);
        cfg_write(bpt_pkg::CAL_C5, c.c5);
        cfg_write(bpt_pkg::CAL_C6, c.c6);
        // indexes past the register list must be ignored
        cfg_write(IdxPastEnd, bpt_pkg::CalW'($urandom));
        cfg_write(IdxTop, bpt_pkg::CalW'($urandom));
        i_cfg_we  <= 1'b0;
        cal_model = c;
    endtask

    task automatic send_reading(input logic [bpt_pkg::RawW-1:0] d1,
                                input logic [bpt_pkg::RawW-1:0] d2,
                                input t_reading want);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_raw_pressure    <= d1;
        i_raw_temperature <= d2;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        expected_readings.push_back(want);
    endtask

    task automatic drain_pipeline();
        i_in_valid <= 1'b0;
        while (expected_readings.size() != 0) @(posedge i_clk);
        repeat (bpt_pkg::NumStages + 2) @(posedge i_clk);
    endtask

    // receiver back-pressure, with a long hold-off in one phase
    initial begin
        forever begin
            @(posedge i_clk);
            if (stall_hold_len > 0) begin
                i_out_stall <= 1'b1;
                repeat (stall_hold_len) @(posedge i_clk);
                stall_hold_len = 0;
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_reading want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_readings.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected result, expected none, got p=%0d t=%0d",
                         $time, o_pressure_pa, o_temperature_deci);
            end else begin
                want = expected_readings.pop_front();
                if (o_pressure_pa !== want.p) begin
                    n_errors++;
                    $display("%0t: pressure_pa expected %0d, got %0d",
                             $time, want.p, o_pressure_pa);
                end
                if (o_temperature_deci !== want.t) begin
                    n_errors++;
                    $display("%0t: temperature_deci expected %0d, got %0d",
                             $time, want.t, o_temperature_deci);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_in_valid && !o_in_stall)
                || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QuietLimit) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        t_cal_set                 cur_cal;
        bpt_pkg::t_cal            c;
        t_row                     row;
        t_reading                 want;
        logic [bpt_pkg::RawW-1:0] d1;
        logic [bpt_pkg::RawW-1:0] d2;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        cur_cal = SET_ZERO;
        for (int i = 0; i < DirRows; i++) begin
            row = DirectedRows[i];
            if (row.cal != cur_cal) begin
                drain_pipeline();
                program_cal(cal_of(row.cal));
                cur_cal = row.cal;
            end
            if (row.fixed) begin
                want.p = row.p;
                want.t = row.t;
            end else begin
                want = compensate(row.d1, row.d2);
            end
            send_reading(row.d1, row.d2, want);
        end

        for (int phase = 0; phase < NumPhases; phase++) begin
            drain_pipeline();
            case (phase)
                0:       c = TypicalCal;
                1:       c = '1;
                2:       c = '0;
                default: c = {vary_word(TypicalCal.c1), vary_word(TypicalCal.c2),
                              vary_word(TypicalCal.c3), vary_word(TypicalCal.c4),
                              vary_word(TypicalCal.c5), vary_word(TypicalCal.c6)};
            endcase
            program_cal(c);
            case (phase % 4)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 49; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 49; end
                default: begin send_idle_pct = 33; recv_stall_pct = 33; end
            endcase
            // long receiver hold-off while transfers keep coming: fills the pipe
            if (phase == 4) stall_hold_len = HoldCycles;
            for (int n = 0; n < PhaseItems; n++) begin
                d1 = ($urandom_range(1) == 1) ? bpt_pkg::RawW'($urandom)
                   : 24'd9085466 + bpt_pkg::RawW'($urandom_range(4194303)) - 24'd2097152;
                d2 = pick_temperature(cal_model);
                send_reading(d1, d2, compensate(d1, d2));
                if (phase == 6 && n == PhaseItems / 2) drain_pipeline();
            end
        end

        drain_pipeline();
        repeat (2 * bpt_pkg::NumStages) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
